// ===== rtl/kcs_pkg.sv =====
// Shared types and codes for the k-closest sorted search block.
package kcs_pkg;

	// Fixed field widths
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned CFG_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned REQ_W    = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

	// Reset value of the neighbour count register
	localparam logic [CFG_W-1:0] K_RESET = 5'd5;

	// Query sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_PLACE,
		ST_LEFT_A,
		ST_LEFT_B,
		ST_LEFT_C,
		ST_RIGHT_A,
		ST_RIGHT_B,
		ST_RIGHT_C,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/k_closest_sorted_search.sv =====
// Top level of the k-closest sorted search block: store, search sequencer and result port.
//
// Usage: an item (req_type, element_value, query_value) transfers at a rising edge with
// start high and busy low. Each result appears on status, element_index and last for
// exactly one cycle with result_valid high; the receiver cannot stall it.
// The user writes neighbour_count via cfg_we / cfg_wdata only while idle; not enforced.
// Clear and append: one result the cycle after the transfer; busy stays low, so a new
// item may follow in the next cycle. An append to a full store or below the last
// stored value is rejected with a status code and stores nothing.
// Query: the lower bound is found by a binary search over the store, each probe a
// read, then a compare. Unless the bound lies at either end, the window is then
// slid one place at a time, each step two reads and one compare, and the k indices
// leave at one per cycle, the final one flagged with last. Busy stays high until
// the last index has been emitted. An empty store answers a query with one result
// of status empty. Reset (arst_n low) empties the store and sets neighbour_count
// to 5; store entries hold no reset value and are read only after they are written.
module k_closest_sorted_search #(
	parameter int unsigned STORE_DEPTH = 2048,
	parameter int unsigned MAX_K       = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [kcs_pkg::REQ_W-1:0]             req_type,
	input  logic signed [kcs_pkg::VALUE_W-1:0]    element_value,
	input  logic signed [kcs_pkg::VALUE_W-1:0]    query_value,
	input  logic                                  cfg_we,
	input  logic [kcs_pkg::CFG_W-1:0]             cfg_wdata,
	output logic                                  result_valid,
	output logic [kcs_pkg::STATUS_W-1:0]          status,
	output logic [$clog2(STORE_DEPTH)-1:0]        element_index,
	output logic                                  last
);

	localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
	localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int unsigned VW    = kcs_pkg::VALUE_W;

	// Element store: one write port and one registered read port
	logic signed [VW-1:0] mem [STORE_DEPTH];
	logic signed [VW-1:0] rd_data_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 wr_en;

	kcs_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]     count_q;
	logic signed [VW-1:0] last_val_q;
	logic [kcs_pkg::CFG_W-1:0] cfg_q;
	logic signed [VW-1:0] q_q;
	logic signed [VW-1:0] a_q;
	logic [CNT_W-1:0]     lo_q, hi_q;
	logic [CNT_W-1:0]     left_q, right_q;
	logic [CNT_W-1:0]     k_q, i_q;

	logic                 out_valid_q;
	logic [kcs_pkg::STATUS_W-1:0] out_status_q;
	logic [IDX_W-1:0]     out_index_q;
	logic                 out_last_q;

	logic                 accept;
	logic [CNT_W-1:0]     mid;
	logic [31:0]          k_raw;
	logic [CNT_W-1:0]     k_eff;
	logic [CNT_W-1:0]     half;
	logic [CNT_W-1:0]     left_c;
	logic [CNT_W:0]       right_c;
	logic [CNT_W-1:0]     left_place;
	logic signed [VW:0]   q_x, a_x, d_x;
	logic signed [VW:0]   diff_near, diff_far;
	logic                 slide_left, slide_right;
	logic                 store_full, out_of_order;

	assign busy   = (state_q != kcs_pkg::ST_IDLE);
	assign accept = start & ~busy;

	// Append checks against the cached last value
	assign store_full   = (count_q == CNT_W'(STORE_DEPTH));
	assign out_of_order = (count_q != '0) && (element_value < last_val_q);
	assign wr_en        = accept && (req_type == kcs_pkg::REQ_APPEND)
	                      && !store_full && !out_of_order;

	// Effective k: clamp register to 1..MAX_K and to the fill
	always_comb begin
		k_raw = 32'(cfg_q);
		if (k_raw == 32'd0) begin
			k_raw = 32'd1;
		end
		if (k_raw > 32'(MAX_K)) begin
			k_raw = 32'(MAX_K);
		end
		if (k_raw > 32'(count_q)) begin
			k_raw = 32'(count_q);
		end
		k_eff = CNT_W'(k_raw);
	end

	// Binary search midpoint
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Initial window around the lower bound
	always_comb begin
		half    = k_q >> 1;
		left_c  = (lo_q >= half) ? (lo_q - half) : '0;
		right_c = {1'b0, left_c} + {1'b0, k_q};
		if (lo_q == '0) begin
			left_place = '0;
		end else if (lo_q == count_q) begin
			left_place = count_q - k_q;
		end else if (right_c > {1'b0, count_q}) begin
			left_place = count_q - k_q;
		end else begin
			left_place = left_c;
		end
	end

	// Slide decisions: a_q holds the first read, rd_data_q the second
	always_comb begin
		q_x        = {q_q[VW-1], q_q};
		a_x        = {a_q[VW-1], a_q};
		d_x        = {rd_data_q[VW-1], rd_data_q};
		diff_near  = q_x - a_x;
		diff_far   = d_x - q_x;
		slide_left = (diff_near <= diff_far);
		slide_right = ((a_x - q_x) < (q_x - d_x));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kcs_pkg::ST_IDLE: begin
				if (accept && (req_type == kcs_pkg::REQ_QUERY) && (count_q != '0)) begin
					state_d = kcs_pkg::ST_SEARCH;
				end
			end
			kcs_pkg::ST_SEARCH: begin
				state_d = (lo_q < hi_q) ? kcs_pkg::ST_COMPARE : kcs_pkg::ST_PLACE;
			end
			kcs_pkg::ST_COMPARE: begin
				state_d = kcs_pkg::ST_SEARCH;
			end
			kcs_pkg::ST_PLACE: begin
				if ((lo_q == '0) || (lo_q == count_q)) begin
					state_d = kcs_pkg::ST_EMIT;
				end else begin
					state_d = kcs_pkg::ST_LEFT_A;
				end
			end
			kcs_pkg::ST_LEFT_A: begin
				state_d = (left_q != '0) ? kcs_pkg::ST_LEFT_B : kcs_pkg::ST_RIGHT_A;
			end
			kcs_pkg::ST_LEFT_B: begin
				state_d = kcs_pkg::ST_LEFT_C;
			end
			kcs_pkg::ST_LEFT_C: begin
				state_d = slide_left ? kcs_pkg::ST_LEFT_A : kcs_pkg::ST_RIGHT_A;
			end
			kcs_pkg::ST_RIGHT_A: begin
				state_d = (right_q < count_q) ? kcs_pkg::ST_RIGHT_B : kcs_pkg::ST_EMIT;
			end
			kcs_pkg::ST_RIGHT_B: begin
				state_d = kcs_pkg::ST_RIGHT_C;
			end
			kcs_pkg::ST_RIGHT_C: begin
				state_d = slide_right ? kcs_pkg::ST_RIGHT_A : kcs_pkg::ST_EMIT;
			end
			kcs_pkg::ST_EMIT: begin
				if (i_q == k_q - 1'b1) begin
					state_d = kcs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kcs_pkg::ST_IDLE;
			end
		endcase
	end

	// Store read address per state
	always_comb begin
		case (state_q)
			kcs_pkg::ST_SEARCH:  rd_addr = mid[IDX_W-1:0];
			kcs_pkg::ST_LEFT_A:  rd_addr = IDX_W'(left_q - 1'b1);
			kcs_pkg::ST_LEFT_B:  rd_addr = IDX_W'(right_q - 1'b1);
			kcs_pkg::ST_RIGHT_A: rd_addr = right_q[IDX_W-1:0];
			kcs_pkg::ST_RIGHT_B: rd_addr = left_q[IDX_W-1:0];
			default:             rd_addr = '0;
		endcase
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= element_value;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kcs_pkg::ST_IDLE;
			count_q     <= '0;
			cfg_q       <= kcs_pkg::K_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (accept && (req_type == kcs_pkg::REQ_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			out_valid_q <= (accept && (req_type != kcs_pkg::REQ_QUERY)
			                && (req_type != kcs_pkg::REQ_APPEND)
			                && (req_type == kcs_pkg::REQ_CLEAR))
			               || (accept && (req_type == kcs_pkg::REQ_APPEND))
			               || (accept && (req_type == kcs_pkg::REQ_QUERY) && (count_q == '0))
			               || (state_q == kcs_pkg::ST_EMIT);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_val_q <= element_value;
		end
		case (state_q)
			kcs_pkg::ST_IDLE: begin
				q_q  <= query_value;
				lo_q <= '0;
				hi_q <= count_q;
				k_q  <= k_eff;
				i_q  <= '0;
			end
			kcs_pkg::ST_COMPARE: begin
				if (rd_data_q < q_q) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q <= mid;
				end
			end
			kcs_pkg::ST_PLACE: begin
				left_q  <= left_place;
				right_q <= left_place + k_q;
			end
			kcs_pkg::ST_LEFT_B, kcs_pkg::ST_RIGHT_B: begin
				a_q <= rd_data_q;
			end
			kcs_pkg::ST_LEFT_C: begin
				if (slide_left) begin
					left_q  <= left_q - 1'b1;
					right_q <= right_q - 1'b1;
				end
			end
			kcs_pkg::ST_RIGHT_C: begin
				if (slide_right) begin
					left_q  <= left_q + 1'b1;
					right_q <= right_q + 1'b1;
				end
			end
			kcs_pkg::ST_EMIT: begin
				i_q <= i_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == kcs_pkg::ST_EMIT) begin
			out_status_q <= kcs_pkg::STAT_OK;
			out_index_q  <= IDX_W'(left_q + i_q);
			out_last_q   <= (i_q == k_q - 1'b1);
		end else begin
			out_index_q <= '0;
			out_last_q  <= 1'b1;
			if (req_type == kcs_pkg::REQ_APPEND) begin
				if (store_full) begin
					out_status_q <= kcs_pkg::STAT_FULL;
				end else if (out_of_order) begin
					out_status_q <= kcs_pkg::STAT_ORDER;
				end else begin
					out_status_q <= kcs_pkg::STAT_OK;
				end
			end else if (req_type == kcs_pkg::REQ_QUERY) begin
				out_status_q <= kcs_pkg::STAT_EMPTY;
			end else begin
				out_status_q <= kcs_pkg::STAT_OK;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign status        = out_status_q;
	assign element_index = out_index_q;
	assign last          = out_last_q;

endmodule

// ===== sim/k_closest_sorted_search_test.sv =====
// Self-checking testbench for the k-closest sorted search block.
module k_closest_sorted_search_test;

	localparam int unsigned    STORE_DEPTH  = 2048;
	localparam int unsigned    MAX_K        = 16;
	localparam int unsigned    IDX_W        = $clog2(STORE_DEPTH);
	localparam int             SETTLE       = 64;
	localparam int             RANDOM_ITEMS = 430;
	localparam int             MAX_REPORTS  = 200;
	localparam logic [kcs_pkg::REQ_W-1:0] REQ_NONE = 2'd3;
	localparam logic signed [kcs_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [kcs_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef enum bit {ITEM_REQ, ITEM_CFG} item_kind_t;

	typedef struct {
		item_kind_t                         kind;
		logic [kcs_pkg::REQ_W-1:0]          req;
		logic signed [kcs_pkg::VALUE_W-1:0] ev;
		logic signed [kcs_pkg::VALUE_W-1:0] qv;
		logic [kcs_pkg::CFG_W-1:0]          kval;
		int                                 gap;
	} item_t;

	typedef struct packed {
		logic [kcs_pkg::STATUS_W-1:0] st;
		logic [IDX_W-1:0]             idx;
		logic                         lst;
	} answer_t;

	// DUT connections
	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               start         = 1'b0;
	logic [kcs_pkg::REQ_W-1:0]          req_type      = '0;
	logic signed [kcs_pkg::VALUE_W-1:0] element_value = '0;
	logic signed [kcs_pkg::VALUE_W-1:0] query_value   = '0;
	logic                               cfg_we        = 1'b0;
	logic [kcs_pkg::CFG_W-1:0]          cfg_wdata     = '0;
	logic                               busy;
	logic                               result_valid;
	logic [kcs_pkg::STATUS_W-1:0]       status;
	logic [IDX_W-1:0]                   element_index;
	logic                               last;

	// Pending stimulus and expected answers
	item_t   pending_q[$];
	answer_t answer_q[$];

	// Shadow of the block state
	logic signed [kcs_pkg::VALUE_W-1:0] shadow_store [STORE_DEPTH];
	int unsigned                        shadow_count = 0;
	logic [kcs_pkg::CFG_W-1:0]          shadow_k     = kcs_pkg::K_RESET;

	// Bookkeeping
	int n_items   = 0;
	int idle_max  = 8;
	int n_xfer    = 0;
	int n_queries = 0;
	int n_checked = 0;
	int n_cfg     = 0;
	int n_err     = 0;
	int calm      = 0;
	int gap_cnt   = 0;

	k_closest_sorted_search #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_K      (MAX_K)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.element_value(element_value),
		.query_value  (query_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.status       (status),
		.element_index(element_index),
		.last         (last)
	);

	always #6 clk = ~clk;

	function automatic longint stored_at(input int unsigned i);
		return longint'(shadow_store[i]);
	endfunction

	// Queue one expected result at the tail
	function automatic void expect_answer(input logic [kcs_pkg::STATUS_W-1:0] st,
			input logic [IDX_W-1:0] idx, input logic lst);
		answer_t a;
		a.st  = st;
		a.idx = idx;
		a.lst = lst;
		answer_q.insert(answer_q.size(), a);
	endfunction

	// Next-state and answers of the block for one accepted request
	function automatic void compute_answers(input logic [kcs_pkg::REQ_W-1:0] req,
			input logic signed [kcs_pkg::VALUE_W-1:0] ev,
			input logic signed [kcs_pkg::VALUE_W-1:0] qv);
		int unsigned n, k, lo, hi, mid, left, right, half;
		longint      q;
		n = shadow_count;
		q = longint'(qv);
		case (req)
			kcs_pkg::REQ_CLEAR: begin
				shadow_count = 0;
				expect_answer(kcs_pkg::STAT_OK, '0, 1'b1);
			end
			kcs_pkg::REQ_APPEND: begin
				if (n >= STORE_DEPTH) begin
					expect_answer(kcs_pkg::STAT_FULL, '0, 1'b1);
				end else if (n > 0 && ev < shadow_store[n-1]) begin
					expect_answer(kcs_pkg::STAT_ORDER, '0, 1'b1);
				end else begin
					shadow_store[n] = ev;
					shadow_count = n + 1;
					expect_answer(kcs_pkg::STAT_OK, '0, 1'b1);
				end
			end
			kcs_pkg::REQ_QUERY: begin
				n_queries++;
				if (n == 0) begin
					expect_answer(kcs_pkg::STAT_EMPTY, '0, 1'b1);
				end else begin
					k = shadow_k;
					if (k < 1) k = 1;
					if (k > MAX_K) k = MAX_K;
					if (k > n) k = n;
					// lower bound: first element not below the query
					lo = 0;
					hi = n;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (stored_at(mid) < q) lo = mid + 1;
						else hi = mid;
					end
					if (lo == 0) begin
						left  = 0;
						right = k;
					end else if (lo == n) begin
						left  = n - k;
						right = n;
					end else begin
						half  = k / 2;
						left  = (lo >= half) ? lo - half : 0;
						right = left + k;
						if (right > n) begin
							right = n;
							left  = n - k;
						end
						// slide left on ties, right only when strictly nearer
						while (left > 0 && q - stored_at(left - 1) <= stored_at(right - 1) - q) begin
							left--;
							right--;
						end
						while (right < n && stored_at(right) - q < q - stored_at(left)) begin
							left++;
							right++;
						end
					end
					for (int unsigned i = 0; i < k; i++)
						expect_answer(kcs_pkg::STAT_OK, IDX_W'(left + i), (i + 1 == k));
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [kcs_pkg::VALUE_W-1:0] clamp32(input longint v);
		if (v > longint'(VAL_MAX)) return VAL_MAX;
		if (v < longint'(VAL_MIN)) return VAL_MIN;
		return VAL_MIN + (v - longint'(VAL_MIN));
	endfunction

	function automatic logic [kcs_pkg::CFG_W-1:0] pick_k();
		case ($urandom_range(0, 9))
			0:       return 5'd0;
			1:       return 5'd1;
			2:       return 5'd16;
			3:       return 5'd31;
			4:       return 5'd17;
			default: return kcs_pkg::CFG_W'($urandom_range(2, 15));
		endcase
	endfunction

	task automatic add_req(input logic [kcs_pkg::REQ_W-1:0] req,
			input logic signed [kcs_pkg::VALUE_W-1:0] ev,
			input logic signed [kcs_pkg::VALUE_W-1:0] qv);
		item_t it;
		it.kind = ITEM_REQ;
		it.req  = req;
		it.ev   = ev;
		it.qv   = qv;
		it.kval = '0;
		it.gap  = $urandom_range(0, idle_max);
		pending_q.insert(pending_q.size(), it);
		if (req != REQ_NONE) n_items++;
	endtask

	task automatic add_cfg(input logic [kcs_pkg::CFG_W-1:0] kval);
		item_t it;
		it.kind = ITEM_CFG;
		it.req  = REQ_NONE;
		it.ev   = '0;
		it.qv   = '0;
		it.kval = kval;
		it.gap  = 0;
		pending_q.insert(pending_q.size(), it);
	endtask

	// Driver: presents queued requests, writes the register only once the block is quiet
	always @(posedge clk or negedge arst_n) begin : drive_proc
		item_t nxt;
		bit    fire, launch, write_k;
		if (!arst_n) begin
			start   <= 1'b0;
			cfg_we  <= 1'b0;
			calm    = 0;
			gap_cnt = 0;
		end else begin
			fire    = start && !busy;
			launch  = 1'b0;
			write_k = 1'b0;
			if (fire) begin
				compute_answers(req_type, element_value, query_value);
				n_xfer++;
			end
			if (answer_q.size() == 0 && !busy && !start && !cfg_we) calm++;
			else calm = 0;
			if ((!start || fire) && pending_q.size() != 0) begin
				nxt = pending_q[0];
				if (nxt.kind == ITEM_CFG) begin
					if (calm >= SETTLE) begin
						write_k = 1'b1;
						void'(pending_q.pop_front());
						shadow_k = nxt.kval;
						n_cfg++;
					end
				end else if (gap_cnt >= nxt.gap) begin
					launch = 1'b1;
					void'(pending_q.pop_front());
				end
			end
			if (launch) gap_cnt = 0;
			else if (!start || fire) gap_cnt++;

			if (launch) begin
				start         <= 1'b1;
				req_type      <= nxt.req;
				element_value <= nxt.ev;
				query_value   <= nxt.qv;
			end else if (fire) begin
				start <= 1'b0;
			end
			cfg_we <= write_k;
			if (write_k) cfg_wdata <= nxt.kval;
		end
	end

	// Monitor: every strobed result is matched against the oldest expected answer
	always @(posedge clk) begin : check_proc
		answer_t got, want;
		if (arst_n && result_valid) begin
			got = '{status, element_index, last};
			n_checked++;
			if (answer_q.size() == 0) begin
				n_err++;
				if (n_err <= MAX_REPORTS)
					$display("%0t: unexpected result: status=%0d index=%0d last=%0b",
						$time, got.st, got.idx, got.lst);
			end else begin
				want = answer_q.pop_front();
				if (got.st !== want.st || got.idx !== want.idx || got.lst !== want.lst) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display({"%0t: mismatch: expected status=%0d index=%0d last=%0b,",
							" got status=%0d index=%0d last=%0b"},
							$time, want.st, want.idx, want.lst, got.st, got.idx, got.lst);
				end
			end
		end
	end

	// Stimulus plan, reset and end of run
	initial begin : main_proc
		logic signed [kcs_pkg::VALUE_W-1:0] vals[$];
		logic signed [kcs_pkg::VALUE_W-1:0] v, qv;
		longint                             acc;
		int                                 m, nq, style, pick;

		// directed: empty store, ignored code, order and equal appends, extremes, ties
		add_req(kcs_pkg::REQ_QUERY, $urandom(), VAL_MAX);
		add_req(REQ_NONE, $urandom(), $urandom());
		add_req(kcs_pkg::REQ_APPEND, VAL_MIN, $urandom());
		add_req(kcs_pkg::REQ_APPEND, -32'sh2_0000, $urandom());
		add_req(kcs_pkg::REQ_APPEND, -32'sh3_0000, $urandom());
		add_req(kcs_pkg::REQ_APPEND, 32'sh0, $urandom());
		add_req(kcs_pkg::REQ_APPEND, 32'sh0, $urandom());
		add_req(kcs_pkg::REQ_APPEND, 32'sh1_0000, $urandom());
		add_req(kcs_pkg::REQ_APPEND, 32'sh3_0000, $urandom());
		add_req(kcs_pkg::REQ_APPEND, VAL_MAX, $urandom());
		add_req(kcs_pkg::REQ_APPEND, VAL_MAX - 1, $urandom());
		add_req(kcs_pkg::REQ_QUERY, $urandom(), VAL_MIN);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), VAL_MAX);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), 32'sh2_0000);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), -32'sh1_0000);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), 32'sh8000);
		add_cfg(5'd16);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), 32'sh0);
		add_cfg(5'd0);
		add_req(kcs_pkg::REQ_QUERY, $urandom(), 32'sh2_0000);
		add_cfg(5'd31);
		add_req(kcs_pkg::REQ_CLEAR, $urandom(), $urandom());
		add_req(kcs_pkg::REQ_QUERY, $urandom(), 32'sh0);
		add_req(kcs_pkg::REQ_APPEND, 32'sh0, $urandom());
		add_req(kcs_pkg::REQ_APPEND, 32'sh1_0000, $urandom());
		add_req(kcs_pkg::REQ_QUERY, $urandom(), VAL_MAX);

		// random phases: fill an ascending store, then query around its contents
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			if ($urandom_range(0, 2) == 0) add_cfg(pick_k());
			if ($urandom_range(0, 5) != 0) begin
				add_req(kcs_pkg::REQ_CLEAR, $urandom(), $urandom());
				vals.delete();
			end
			style = $urandom_range(0, 2);
			m = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
			case (style)
				0:       acc = longint'($urandom_range(0, 200)) - 100;
				1:       acc = (longint'($urandom_range(0, 2000)) - 1000) <<< 16;
				default: acc = longint'(VAL_MIN) + longint'($urandom_range(0, 32'h4000_0000));
			endcase
			if (vals.size() != 0) acc = longint'(vals[$]);
			for (int i = 0; i < m; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					// noise: arbitrary value, usually out of order
					v = $urandom();
				end else begin
					case (style)
						0:       acc = acc + $urandom_range(0, 2);
						1:       acc = acc + (longint'($urandom_range(0, 4)) <<< 16);
						default: acc = acc + longint'($urandom_range(0, 32'h1000_0000));
					endcase
					v = clamp32(acc);
				end
				add_req(kcs_pkg::REQ_APPEND, v, $urandom());
				if (vals.size() < STORE_DEPTH && (vals.size() == 0 || v >= vals[$])) begin
					vals.insert(vals.size(), v);
					acc = longint'(v);
				end
			end
			nq = $urandom_range(1, 6);
			for (int i = 0; i < nq; i++) begin
				pick = $urandom_range(0, 4);
				if (vals.size() == 0 || pick == 0) begin
					qv = $urandom();
				end else if (pick == 1) begin
					qv = clamp32(longint'(vals[$urandom_range(0, vals.size() - 1)])
						+ $urandom_range(0, 2) - 1);
				end else if (pick == 2 && vals.size() > 1) begin
					m  = $urandom_range(0, vals.size() - 2);
					qv = clamp32((longint'(vals[m]) + longint'(vals[m+1])) / 2);
				end else if (pick == 3) begin
					qv = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
				end else begin
					qv = $urandom_range(0, 1) ? clamp32(longint'(vals[0]) - $urandom_range(1, 3))
						: clamp32(longint'(vals[$]) + $urandom_range(1, 3));
				end
				add_req(kcs_pkg::REQ_QUERY, $urandom(), qv);
			end
			if ($urandom_range(0, 15) == 0) add_req(REQ_NONE, $urandom(), $urandom());
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// drain: everything sent and every answer seen, then let the block settle
		while (pending_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Run: %0d transfers (%0d queries) and %0d register writes, %0d results checked;",
			n_xfer, n_queries, n_cfg, n_checked);
		$display("covered empty, out-of-order, clamped and tied windows, k from 0 to 31.");
		if (n_err == 0) begin
			$display("** k_closest_sorted_search: PASSED **");
		end else begin
			$display("%0d errors", n_err);
			$display("** k_closest_sorted_search: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin : timeout_proc
		#10_000_000;
		$display("Timeout with %0d requests pending and %0d answers outstanding",
			pending_q.size(), answer_q.size());
		$display("** k_closest_sorted_search: FAILED **");
		$finish;
	end

endmodule
